// ----- rtl/core/swmq_pkg.sv -----
package swmq_pkg;

  // field widths of the stream items
  localparam int unsigned ValueW    = 32;
  localparam int unsigned MinW      = 32;
  localparam int unsigned OccW      = 11;
  localparam int unsigned InTdataW  = 32;
  localparam int unsigned OutTdataW = 48;

  // output tdata layout, lowest bit up
  localparam int unsigned MinLsb      = 0;
  localparam int unsigned NonemptyBit = MinLsb + MinW;
  localparam int unsigned OccLsb      = NonemptyBit + 1;
  localparam int unsigned RejBit      = OccLsb + OccW;
  localparam int unsigned OutPadW     = OutTdataW - RejBit - 1;

  typedef enum logic {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  localparam int unsigned StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam step_t StepIdle   = 4'd0;
  localparam step_t StepDisp   = 4'd1;
  localparam step_t StepPopChk = 4'd2;
  localparam step_t StepFChk   = 4'd3;
  localparam step_t StepXRd    = 4'd4;
  localparam step_t StepXWr    = 4'd5;
  localparam step_t StepPopF   = 4'd6;
  localparam step_t StepPopLd  = 4'd7;
  localparam step_t StepPush   = 4'd8;
  localparam step_t StepEmit   = 4'd9;

  typedef enum logic [2:0] {
    CondNever,
    CondAlways,
    CondInValid,
    CondCmdPush,
    CondEmpty,
    CondFrontNz,
    CondBackGt1,
    CondOutFree
  } cond_e;

  typedef struct packed {
    logic  ready;
    logic  chk_empty;
    logic  rd_back;
    logic  xfer;
    logic  pop_dec;
    logic  pop_ld;
    logic  push;
    logic  emit;
    cond_e cond;
    step_t target;
    logic  hold;
  } uword_t;

  typedef struct packed {
    logic load_in;
    logic chk_empty;
    logic rd_back;
    logic xfer;
    logic pop_dec;
    logic pop_ld;
    logic push;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic cmd_push;
    logic empty;
    logic front_nz;
    logic back_gt1;
    logic out_free;
  } dp_stat_t;

  // microprogram: a taken condition jumps to target, otherwise hold or step on
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w = '{ready: 1'b0, chk_empty: 1'b0, rd_back: 1'b0, xfer: 1'b0, pop_dec: 1'b0,
          pop_ld: 1'b0, push: 1'b0, emit: 1'b0, cond: CondAlways, target: StepIdle,
          hold: 1'b0};
    case (step)
      StepIdle: begin
        w.ready  = 1'b1;
        w.cond   = CondInValid;
        w.target = StepDisp;
        w.hold   = 1'b1;
      end
      StepDisp: begin
        w.cond   = CondCmdPush;
        w.target = StepPush;
      end
      StepPopChk: begin
        w.chk_empty = 1'b1;
        w.cond      = CondEmpty;
        w.target    = StepEmit;
      end
      StepFChk: begin
        w.cond   = CondFrontNz;
        w.target = StepPopF;
      end
      StepXRd: begin
        w.rd_back = 1'b1;
        w.cond    = CondNever;
      end
      StepXWr: begin
        w.xfer   = 1'b1;
        w.cond   = CondBackGt1;
        w.target = StepXRd;
      end
      StepPopF: begin
        w.pop_dec = 1'b1;
        w.cond    = CondNever;
      end
      StepPopLd: begin
        w.pop_ld = 1'b1;
        w.cond   = CondAlways;
        w.target = StepEmit;
      end
      StepPush: begin
        w.push   = 1'b1;
        w.cond   = CondAlways;
        w.target = StepEmit;
      end
      StepEmit: begin
        w.emit   = 1'b1;
        w.cond   = CondOutFree;
        w.target = StepIdle;
        w.hold   = 1'b1;
      end
      default: begin
        w.cond   = CondAlways;
        w.target = StepIdle;
      end
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/core/swmq_datapath.sv -----
module swmq_datapath #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_cmd_i,
  input  logic [swmq_pkg::ValueW-1:0]         in_value_i,
  input  swmq_pkg::dp_ctrl_t                  ctrl_i,
  output swmq_pkg::dp_stat_t                  stat_o,
  input  logic                                m_axis_tready,
  output logic                                m_axis_tvalid,
  output logic [swmq_pkg::OutTdataW-1:0]      m_axis_tdata
);

  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned AddrW = $clog2(CAPACITY);

  logic [DATA_WIDTH-1:0] back_mem  [CAPACITY];
  logic [DATA_WIDTH-1:0] front_mem [CAPACITY];

  logic                  cmd_q;
  logic [DATA_WIDTH-1:0] val_q;
  logic [CntW-1:0]       fd_q, fd_d;
  logic [CntW-1:0]       bd_q, bd_d;
  logic [DATA_WIDTH-1:0] ftop_q, btop_q;
  logic [DATA_WIDTH-1:0] back_rd_q, front_rd_q;
  logic                  rej_q;
  logic                  out_valid_q, out_valid_d;
  logic [swmq_pkg::OutTdataW-1:0] out_data_q;

  logic [CntW-1:0]       occ;
  logic                  empty, full, push_en;
  logic [CntW-1:0]       bd_m1, fd_m2;
  logic [DATA_WIDTH-1:0] push_min, xfer_min, mn;
  logic [swmq_pkg::MinW-1:0] mn_out;

  assign occ     = fd_q + bd_q;
  assign empty   = (occ == '0);
  assign full    = (occ >= CntW'(CAPACITY));
  assign push_en = ctrl_i.push && !full;
  assign bd_m1   = bd_q - CntW'(1);
  assign fd_m2   = fd_q - CntW'(2);

  assign push_min = (bd_q == '0 || $signed(val_q) < $signed(btop_q)) ? val_q : btop_q;
  assign xfer_min = (fd_q == '0 || $signed(back_rd_q) < $signed(ftop_q)) ? back_rd_q : ftop_q;

  always_comb begin
    if (fd_q != '0 && bd_q != '0) begin
      mn = ($signed(ftop_q) < $signed(btop_q)) ? ftop_q : btop_q;
    end else if (fd_q != '0) begin
      mn = ftop_q;
    end else if (bd_q != '0) begin
      mn = btop_q;
    end else begin
      mn = '0;
    end
  end

  assign mn_out = swmq_pkg::MinW'($signed(mn));

  // stack memories: back keeps values, front keeps running minima
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      back_mem[bd_q[AddrW-1:0]] <= val_q;
    end
    if (ctrl_i.rd_back) begin
      back_rd_q <= back_mem[bd_m1[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.xfer) begin
      front_mem[fd_q[AddrW-1:0]] <= xfer_min;
    end
    if (ctrl_i.pop_dec) begin
      front_rd_q <= front_mem[fd_m2[AddrW-1:0]];
    end
  end

  always_comb begin
    fd_d = fd_q;
    bd_d = bd_q;
    if (ctrl_i.xfer) begin
      fd_d = fd_q + CntW'(1);
      bd_d = bd_q - CntW'(1);
    end
    if (ctrl_i.pop_dec) begin
      fd_d = fd_q - CntW'(1);
    end
    if (push_en) begin
      bd_d = bd_q + CntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fd_q        <= '0;
      bd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fd_q        <= fd_d;
      bd_q        <= bd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      cmd_q <= in_cmd_i;
      val_q <= DATA_WIDTH'($signed(in_value_i));
      rej_q <= 1'b0;
    end else if ((ctrl_i.chk_empty && empty) || (ctrl_i.push && full)) begin
      rej_q <= 1'b1;
    end
    if (ctrl_i.xfer) begin
      ftop_q <= xfer_min;
    end else if (ctrl_i.pop_ld && fd_q != '0) begin
      ftop_q <= front_rd_q;
    end
    if (push_en) begin
      btop_q <= push_min;
    end
    if (ctrl_i.emit) begin
      out_data_q <= {{swmq_pkg::OutPadW{1'b0}}, rej_q, swmq_pkg::OccW'(occ), !empty, mn_out};
    end
  end

  assign stat_o.cmd_push = (cmd_q == swmq_pkg::CmdPush);
  assign stat_o.empty    = empty;
  assign stat_o.front_nz = (fd_q != '0);
  assign stat_o.back_gt1 = (bd_q > CntW'(1));
  assign stat_o.out_free = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- rtl/core/sliding_window_min_queue_core.sv -----
// steps: idle, dispatch, then push for a push, or pop check, front check, pop and
// pop load for a pop, then emit (a pop on an empty window goes straight to emit);
// a back stack spill onto an empty front stack adds a read and a write step per value
// one request at a time: next request taken in the cycle after the result is loaded;
// the single-port stack memories set the step count
// reset (async, active low) empties both stacks; memory contents are not cleared
module sliding_window_min_queue_core #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [swmq_pkg::InTdataW-1:0]      s_axis_tdata,  // value[31:0]
  input  logic                               s_axis_tuser,  // cmd
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // window_min[31:0], window_nonempty[32], occupancy[43:33], rejected[44], zero[47:45]
  output logic [swmq_pkg::OutTdataW-1:0]     m_axis_tdata
);

  swmq_pkg::step_t    upc_q, upc_d;
  swmq_pkg::uword_t   uw;
  swmq_pkg::dp_ctrl_t ctrl;
  swmq_pkg::dp_stat_t stat;
  logic               taken;

  assign uw = swmq_pkg::ucode_rom(upc_q);

  always_comb begin
    case (uw.cond)
      swmq_pkg::CondNever:   taken = 1'b0;
      swmq_pkg::CondAlways:  taken = 1'b1;
      swmq_pkg::CondInValid: taken = s_axis_tvalid;
      swmq_pkg::CondCmdPush: taken = stat.cmd_push;
      swmq_pkg::CondEmpty:   taken = stat.empty;
      swmq_pkg::CondFrontNz: taken = stat.front_nz;
      swmq_pkg::CondBackGt1: taken = stat.back_gt1;
      swmq_pkg::CondOutFree: taken = stat.out_free;
      default:               taken = 1'b0;
    endcase
  end

  // next step
  always_comb begin
    if (taken) begin
      upc_d = uw.target;
    end else if (uw.hold) begin
      upc_d = upc_q;
    end else begin
      upc_d = upc_q + swmq_pkg::StepW'(1);
    end
  end

  // control outputs
  always_comb begin
    ctrl.load_in   = uw.ready && s_axis_tvalid;
    ctrl.chk_empty = uw.chk_empty;
    ctrl.rd_back   = uw.rd_back;
    ctrl.xfer      = uw.xfer;
    ctrl.pop_dec   = uw.pop_dec;
    ctrl.pop_ld    = uw.pop_ld;
    ctrl.push      = uw.push;
    ctrl.emit      = uw.emit && stat.out_free;
  end

  assign s_axis_tready = uw.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= swmq_pkg::StepIdle;
    end else begin
      upc_q <= upc_d;
    end
  end

  swmq_datapath #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_cmd_i      (s_axis_tuser),
    .in_value_i    (s_axis_tdata),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .m_axis_tready (m_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ----- rtl/core/swmq_checker.sv -----
module swmq_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [swmq_pkg::OutTdataW-1:0] m_axis_tdata
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while another is in work");

  // a nonempty window reports nonzero occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[swmq_pkg::NonemptyBit] |->
      m_axis_tdata[swmq_pkg::RejBit-1:swmq_pkg::OccLsb] != '0)
    else $error("nonempty window with zero occupancy");

  // an empty window reports zero minimum and zero occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[swmq_pkg::NonemptyBit] |->
      m_axis_tdata[swmq_pkg::NonemptyBit-1:0] == '0 &&
      m_axis_tdata[swmq_pkg::RejBit-1:swmq_pkg::OccLsb] == '0)
    else $error("empty window with nonzero minimum or occupancy");

endmodule

bind sliding_window_min_queue_core swmq_checker u_swmq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned WinCap     = 1024;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [swmq_pkg::MinW-1:0] wmin;
    logic                      nonempty;
    logic [swmq_pkg::OccW-1:0] occ;
    logic                      rej;
  } win_result_t;

  // scoreboard: keeps the window as a plain fifo and scans it for the minimum
  class min_window_sb;
    logic signed [swmq_pkg::ValueW-1:0] window_vals[$];
    win_result_t                        pending_results[$];
    int unsigned                        errors;
    int unsigned                        n_push;
    int unsigned                        n_pop;
    int unsigned                        n_rej;
    int unsigned                        n_checked;
    int unsigned                        peak_occ;

    function int unsigned window_size();
      return window_vals.size();
    endfunction

    function int unsigned pending_count();
      return pending_results.size();
    endfunction

    function void note_request(swmq_pkg::cmd_e cmd, logic [swmq_pkg::ValueW-1:0] value);
      win_result_t                        r;
      logic signed [swmq_pkg::ValueW-1:0] m;
      r.rej = 1'b0;
      if (cmd == swmq_pkg::CmdPush) begin
        n_push++;
        if (window_vals.size() >= WinCap) r.rej = 1'b1;
        else window_vals.push_back(value);
      end else begin
        n_pop++;
        if (window_vals.size() == 0) r.rej = 1'b1;
        else void'(window_vals.pop_front());
      end
      if (r.rej) n_rej++;
      if (window_vals.size() > peak_occ) peak_occ = window_vals.size();
      m = '0;
      foreach (window_vals[i]) begin
        if (i == 0 || window_vals[i] < m) m = window_vals[i];
      end
      r.wmin     = m;
      r.nonempty = (window_vals.size() != 0);
      r.occ      = swmq_pkg::OccW'(window_vals.size());
      pending_results.push_back(r);
    endfunction

    function void report(string fld, logic [swmq_pkg::MinW-1:0] exp_v,
                         logic [swmq_pkg::MinW-1:0] act_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, fld, exp_v, act_v);
    endfunction

    function void check_result(logic [swmq_pkg::OutTdataW-1:0] tdata);
      win_result_t r;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %0h, none pending", $time, tdata);
        return;
      end
      r = pending_results.pop_front();
      n_checked++;
      if (tdata[swmq_pkg::MinLsb +: swmq_pkg::MinW] !== r.wmin)
        report("window_min", r.wmin, tdata[swmq_pkg::MinLsb +: swmq_pkg::MinW]);
      if (tdata[swmq_pkg::NonemptyBit] !== r.nonempty)
        report("window_nonempty", swmq_pkg::MinW'(r.nonempty),
               swmq_pkg::MinW'(tdata[swmq_pkg::NonemptyBit]));
      if (tdata[swmq_pkg::OccLsb +: swmq_pkg::OccW] !== r.occ)
        report("occupancy", swmq_pkg::MinW'(r.occ),
               swmq_pkg::MinW'(tdata[swmq_pkg::OccLsb +: swmq_pkg::OccW]));
      if (tdata[swmq_pkg::RejBit] !== r.rej)
        report("rejected", swmq_pkg::MinW'(r.rej), swmq_pkg::MinW'(tdata[swmq_pkg::RejBit]));
      if (tdata[swmq_pkg::OutTdataW-1 -: swmq_pkg::OutPadW] !== '0)
        report("padding", '0,
               swmq_pkg::MinW'(tdata[swmq_pkg::OutTdataW-1 -: swmq_pkg::OutPadW]));
    endfunction
  endclass

  logic                           clk_i;
  logic                           rst_ni;
  logic                           s_axis_tvalid;
  logic                           s_axis_tready;
  logic [swmq_pkg::InTdataW-1:0]  s_axis_tdata;
  logic                           s_axis_tuser;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [swmq_pkg::OutTdataW-1:0] m_axis_tdata;

  min_window_sb sb;
  int unsigned  cycles = 0;
  int unsigned  burst_left;
  int unsigned  rx_left = 0;
  bit           idle_off;

  sliding_window_min_queue_core #(
    .CAPACITY  (WinCap),
    .DATA_WIDTH(32)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
  end

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, sb.pending_count());
      $display("Regression FAIL");
      $finish;
    end
  end

  // result side: alternating ready and stall runs of random length, ready held high while idle_off is set
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if (idle_off) begin
      m_axis_tready <= 1'b1;
    end else if (rx_left == 0) begin
      m_axis_tready <= !m_axis_tready;
      rx_left       <= m_axis_tready ? $urandom_range(1, 6) : $urandom_range(1, 12);
    end else begin
      rx_left <= rx_left - 1;
    end
  end

  function automatic logic [swmq_pkg::ValueW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1:       return swmq_pkg::ValueW'($signed($urandom_range(0, 15)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_req(swmq_pkg::cmd_e cmd, logic [swmq_pkg::ValueW-1:0] value);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(cmd, value);
    burst_left = burst_left - 1;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!idle_off) begin
        gap = $urandom_range(1, 6);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic run_mixed(int unsigned count, int unsigned push_pct);
    swmq_pkg::cmd_e c;
    repeat (count) begin
      c = ($urandom_range(0, 99) < push_pct) ? swmq_pkg::CmdPush : swmq_pkg::CmdPop;
      send_req(c, pick_value());
    end
  endtask

  initial begin
    int unsigned    full_hits;
    int unsigned    fill_items;
    swmq_pkg::cmd_e c;
    sb            = new;
    burst_left    = 1;
    idle_off      = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tuser  <= swmq_pkg::CmdPush;
    s_axis_tdata  <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pop on empty, extreme values, spill on first pop, drain, pop on empty again
    send_req(swmq_pkg::CmdPop, 32'hffff_ffff);
    send_req(swmq_pkg::CmdPush, 32'h7fff_ffff);
    send_req(swmq_pkg::CmdPush, 32'h8000_0000);
    send_req(swmq_pkg::CmdPush, 32'h0000_0000);
    send_req(swmq_pkg::CmdPush, 32'hffff_ffff);
    send_req(swmq_pkg::CmdPush, 32'h0000_0001);
    send_req(swmq_pkg::CmdPush, 32'haaaa_aaaa);
    send_req(swmq_pkg::CmdPush, 32'h5555_5555);
    send_req(swmq_pkg::CmdPop, 32'h0000_0000);
    send_req(swmq_pkg::CmdPop, 32'h5555_5555);
    send_req(swmq_pkg::CmdPush, 32'h8000_0001);
    send_req(swmq_pkg::CmdPush, 32'h7fff_fffe);
    repeat (7) send_req(swmq_pkg::CmdPop, $urandom);
    send_req(swmq_pkg::CmdPop, 32'haaaa_aaaa);

    // shallow window, often empty
    run_mixed(200, 55);

    // fill to capacity, then keep pushing against the full window
    full_hits  = 0;
    fill_items = 0;
    idle_off   = 1'b1;
    while (full_hits < 24) begin
      if (fill_items == 400) idle_off = 1'b0;
      if (sb.window_size() == WinCap) begin
        full_hits++;
        c = ($urandom_range(0, 3) == 0) ? swmq_pkg::CmdPop : swmq_pkg::CmdPush;
      end else begin
        c = ($urandom_range(0, 9) == 0) ? swmq_pkg::CmdPop : swmq_pkg::CmdPush;
      end
      send_req(c, pick_value());
      fill_items++;
    end
    idle_off = 1'b0;

    // deep window, pop heavy
    run_mixed(150, 35);

    s_axis_tvalid <= 1'b0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);

    $display("checked %0d results: %0d pushes, %0d pops, %0d rejected",
             sb.n_checked, sb.n_push, sb.n_pop, sb.n_rej);
    $display("peak window occupancy %0d of %0d, %0d errors", sb.peak_occ, WinCap, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
